// ===== sv/wbps_pkg.sv =====
// Shared constants, register codes and types of the wildcard byte pattern scanner.
package wbps_pkg;

    // Sizing
    localparam int PATTERN_MAX = 32;
    localparam int ADDR_BITS   = 24;
    localparam int BYTE_W      = 8;
    localparam int CFG_POS     = 32;
    localparam int LEN_REG_W   = 6;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W       = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
    localparam int PAT_REGS    = 4;
    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int REG_IDX_W   = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WILD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PLEN = 3'd5;

    // Pattern aligned to window slots: slot w holds pattern position len-1-w
    typedef struct packed {
        logic [LEN_W-1:0]                    len;
        logic [PATTERN_MAX-1:0]              care;
        logic [PATTERN_MAX-1:0][BYTE_W-1:0]  bytes;
    } t_align;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] addr;
    } t_result;

endpackage

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// Top level: input register, scan core, result register and register port.
// Scans a byte stream for a pattern of up to 32 bytes where any position may
// be a wildcard. One byte is accepted every cycle unless the input stalls;
// each byte is held in the input register, then its result, if any, goes to
// the result register. Throughput is one byte per cycle when not stalled,
// set by the 32-slot window compare that runs in full on every byte. A
// stalled result holds the byte in the input register, and the input stalls
// only while both are full and the result is stalled. Each scan ends with
// the byte flagged last and gives exactly one result: the start index of the
// first match, or not found. Patterns are loaded through the register port;
// the user must do so while the block is idle; the block does not enforce it.
module wildcard_byte_pattern_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wbps_pkg::BYTE_W-1:0]         i_code_byte,
    input  logic                                i_last_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [wbps_pkg::ADDR_BITS-1:0]      o_match_address,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]        paddr,
    input  logic [wbps_pkg::PDATA_W-1:0]        pwdata,
    output logic [wbps_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    wbps_pkg::t_align                    cfg;
    wbps_pkg::t_result                   scan_res;
    wbps_pkg::t_result                   r_out;
    logic                                scan_res_valid;
    logic                                r_s1_valid;
    logic                                n_s1_valid;
    logic [wbps_pkg::BYTE_W-1:0]         r_s1_byte;
    logic                                r_s1_last;
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic                                out_free;
    logic                                s1_go;
    logic                                in_take;

    wbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wbps_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_go),
        .i_byte      (r_s1_byte),
        .i_last      (r_s1_last),
        .i_cfg       (cfg),
        .o_res_valid (scan_res_valid),
        .o_res       (scan_res)
    );

    // Handshake: stage moves when the result register is free or draining
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_go       = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign n_s1_valid  = (r_s1_valid && !s1_go) || in_take;
    assign n_out_valid = (r_out_valid && i_out_stall) || (s1_go && scan_res_valid);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_code_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && scan_res_valid) begin
            r_out <= scan_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out.found;
    assign o_match_address = r_out.addr;

`ifndef NO_ASSERTIONS
    // Input stalls only behind a full stage and a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A byte that cannot move stays in the input register unchanged
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=>
        (r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last)))
        else $error("held byte lost or changed");

    // A new result only comes from a byte that left the input register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(s1_go))
        else $error("result appeared without a processed byte");
`endif

endmodule

// ===== sv/wbps_regs.sv =====
// Configuration register file and window-aligned pattern derivation.
module wbps_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::PDATA_W-1:0]  pwdata,
    output logic [wbps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output wbps_pkg::t_align              o_cfg
);

    localparam int PM   = wbps_pkg::PATTERN_MAX;
    localparam int LW   = wbps_pkg::LEN_W;
    localparam int CW   = wbps_pkg::CMP_W;
    localparam int LRW  = wbps_pkg::LEN_REG_W;
    localparam int NPOS = wbps_pkg::CFG_POS;
    localparam int DW   = wbps_pkg::PDATA_W;
    localparam int IW   = wbps_pkg::REG_IDX_W;

    logic [wbps_pkg::PAT_REGS-1:0][DW-1:0]      r_pat;
    logic [NPOS-1:0]                            r_wild;
    logic [LRW-1:0]                             r_len;
    logic [IW-1:0]                              reg_idx;
    logic                                       wr_en;
    logic [NPOS-1:0][wbps_pkg::BYTE_W-1:0]      pat_flat;
    logic [LW-1:0]                              len_eff;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[wbps_pkg::PADDR_W-1 -: IW];
    assign wr_en    = psel && penable && pwrite;
    assign pat_flat = r_pat;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_wild <= '0;
            r_len  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                wbps_pkg::REG_PAT0: r_pat[0] <= pwdata;
                wbps_pkg::REG_PAT1: r_pat[1] <= pwdata;
                wbps_pkg::REG_PAT2: r_pat[2] <= pwdata;
                wbps_pkg::REG_PAT3: r_pat[3] <= pwdata;
                wbps_pkg::REG_WILD: r_wild   <= pwdata[NPOS-1:0];
                wbps_pkg::REG_PLEN: r_len    <= pwdata[LRW-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            wbps_pkg::REG_PAT0: prdata = r_pat[0];
            wbps_pkg::REG_PAT1: prdata = r_pat[1];
            wbps_pkg::REG_PAT2: prdata = r_pat[2];
            wbps_pkg::REG_PAT3: prdata = r_pat[3];
            wbps_pkg::REG_WILD: prdata = DW'(r_wild);
            wbps_pkg::REG_PLEN: prdata = DW'(r_len);
            default:            prdata = '0;
        endcase
    end

    // Lengths above the window size act as the full window
    assign len_eff = (CW'(r_len) > CW'(PM)) ? LW'(PM) : LW'(r_len);

    // Slot w compares against pattern position len-1-w; positions past the
    // register space compare against zero and are never wildcards
    always_comb begin
        logic [CW-1:0] kk;
        kk = '0;
        o_cfg.len = len_eff;
        for (int w = 0; w < PM; w++) begin
            o_cfg.care[w]  = 1'b0;
            o_cfg.bytes[w] = '0;
            if (CW'(w) < CW'(len_eff)) begin
                kk = CW'(len_eff) - CW'(w) - CW'(1);
                if (kk < CW'(NPOS)) begin
                    o_cfg.bytes[w] = pat_flat[kk[$clog2(NPOS)-1:0]];
                    o_cfg.care[w]  = !r_wild[kk[$clog2(NPOS)-1:0]];
                end else begin
                    o_cfg.care[w]  = 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/wbps_scan.sv =====
// Sliding byte window, byte index and first-match detection for one scan.
module wbps_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [wbps_pkg::BYTE_W-1:0]    i_byte,
    input  logic                           i_last,
    input  wbps_pkg::t_align               i_cfg,
    output logic                           o_res_valid,
    output wbps_pkg::t_result              o_res
);

    localparam int PM  = wbps_pkg::PATTERN_MAX;
    localparam int AW  = wbps_pkg::ADDR_BITS;
    localparam int AW1 = wbps_pkg::ADDR_BITS + 1;

    logic [PM-1:0][wbps_pkg::BYTE_W-1:0] r_window;
    logic [PM-1:0][wbps_pkg::BYTE_W-1:0] n_window;
    logic [AW-1:0]                       r_count;
    logic                                r_done;
    logic                                all_eq;
    logic                                enough;
    logic                                hit;
    logic [AW1-1:0]                      start_sum;

    // Window after this byte, newest in slot 0
    always_comb begin
        n_window[0] = i_byte;
        for (int w = 1; w < PM; w++) begin
            n_window[w] = r_window[w-1];
        end
    end

    // Parallel compare of every cared-for slot
    always_comb begin
        all_eq = 1'b1;
        for (int w = 0; w < PM; w++) begin
            if (i_cfg.care[w] && (n_window[w] != i_cfg.bytes[w])) begin
                all_eq = 1'b0;
            end
        end
    end

    // Match must lie wholly in this scan: idx + 1 >= len
    assign enough    = (AW1'(r_count) + AW1'(1)) >= AW1'(i_cfg.len);
    assign hit       = !r_done && (i_cfg.len != '0) && enough && all_eq;
    assign start_sum = AW1'(r_count) + AW1'(1) - AW1'(i_cfg.len);

    // Result: first match, or not found on the final byte
    assign o_res_valid = hit || (i_last && !r_done);
    assign o_res.found = hit;
    assign o_res.addr  = hit ? start_sum[AW-1:0] : '0;

    // Window holds no reset: slots older than the byte count never match
    always_ff @(posedge i_clk) begin
        if (i_step && !r_done) begin
            r_window <= n_window;
        end
    end

    // Scan state: saturating count, done flag, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_count <= '0;
                r_done  <= 1'b0;
            end else begin
                if (r_count != '1) begin
                    r_count <= r_count + AW'(1);
                end
                if (hit) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
